// File: sv/fvsq_pkg.sv
// fvsq_pkg: types, constants and helpers for the four voice square sequencer
// no dependencies
package fvsq_pkg;

    localparam int TRACKS       = 4;
    localparam int SONG_BYTES   = 4096;
    localparam int DECAY_PERIOD = 384;
    localparam int AW           = $clog2(SONG_BYTES);
    localparam int TW           = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CFG_IW       = 3;
    localparam int CFG_DW       = 16;

    localparam logic [CFG_IW-1:0] REG_STEP_PERIOD = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TRACK_COUNT = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TRACK_START0 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TRACK_START1 = 3'd4;
    localparam logic [CFG_IW-1:0] REG_TRACK_START2 = 3'd5;
    localparam logic [CFG_IW-1:0] REG_TRACK_START3 = 3'd6;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] address;
        logic [7:0]  data;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] level;
        logic       playing;
        logic       ended;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LOAD, S_LOADWAIT, S_SVC, S_READ, S_PARSE,
        S_NOTE, S_NOTEWAIT, S_MIX, S_DONE, S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear_voices;
        logic load_init;     // set step/decay counters, zero countdowns
        logic load_ptr;      // load pointer of track r_trk, issue read
        logic load_cur;      // current byte from read data
        logic step_dec;      // decrement step counter
        logic svc_count;     // countdown check/decrement
        logic parse;         // apply current byte, advance pointer, read
        logic take_byte;     // current byte = read data
        logic note;          // apply note from current byte
        logic note_adv;      // advance pointer, read
        logic step_reload;
        logic mix;
        logic stop;
        logic run_on;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       svc_hit;     // step counter below track count
        logic       go_parse;    // countdown was zero and byte nonzero
        logic       is_note;
        logic       is_end;
        logic       runaway;
        logic       running;
        logic       loop_on;     // loop enable register
        logic [TW-1:0] svc_trk;
    } t_sts;

    function automatic logic [10:0] base_period(input logic [3:0] p);
        unique case (p)
            4'd0: return 11'd1911;  4'd1: return 11'd1804;
            4'd2: return 11'd1703;  4'd3: return 11'd1607;
            4'd4: return 11'd1517;  4'd5: return 11'd1432;
            4'd6: return 11'd1351;  4'd7: return 11'd1276;
            4'd8: return 11'd1204;  4'd9: return 11'd1136;
            4'd10: return 11'd1073; 4'd11: return 11'd1012;
            default: return 11'd0;
        endcase
    endfunction

endpackage

// File: sv/four_voice_square_music_sequencer.sv
// four_voice_square_music_sequencer: top level
// depends on fvsq_pkg, fvsq_ctrl, fvsq_dp
//
// usage
// - input channel: one beat per command (tick, write song byte, start, stop)
// - output channel: exactly one result beat per input beat (level, playing, ended)
// - configuration: write enable, register index, 16-bit data; write only while idle
// - a running tick walks the serviced track's song bytes and start loads each
//   track pointer in turn, both through the one song memory read port
// - one beat is in flight at a time; the next beat is taken once the result
//   register is free or being drained
// - reset clears counters, voice state and configuration; song memory is
//   undefined until written
// - a stalled receiver holds the result; input stays not ready meanwhile
module four_voice_square_music_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fvsq_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fvsq_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [fvsq_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [fvsq_pkg::CFG_DW-1:0] i_cfg_data
);
    import fvsq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_we, w_ended;
    logic [TW-1:0] w_trk;
    logic [7:0] w_level;

    fvsq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_command(i_in_data.command),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_mem_we(w_we), .o_trk(w_trk),
        .o_ended(w_ended)
    );

    fvsq_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_trk(w_trk),
        .i_mem_we(w_we), .i_beat(i_in_data), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_sts(w_sts),
        .o_level(w_level)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            o_out_data.level <= w_level;
            o_out_data.playing <= w_sts.running;
            o_out_data.ended <= w_ended;
        end
    end
endmodule

// File: sv/fvsq_ctrl.sv
// fvsq_ctrl: sequencing state machine for one input beat
// depends on fvsq_pkg
module fvsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  fvsq_pkg::t_sts    i_sts,
    output fvsq_pkg::t_cmd    o_cmd,
    output logic              o_mem_we,
    output logic [fvsq_pkg::TW-1:0] o_trk,
    output logic              o_ended
);
    import fvsq_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_cmd;
    logic [TW-1:0] r_trk, n_trk;
    logic r_ended, n_ended;
    logic r_oval, n_oval;

    // the serviced track is selected straight from the step counter
    assign o_trk = (r_state == S_SVC) ? i_sts.svc_trk : r_trk;
    assign o_ended = r_ended;
    assign o_out_valid = r_oval;
    // new beat only when the result slot is free or leaving
    assign o_in_ready = (r_state == S_IDLE) && (!r_oval || i_out_ready);
    assign o_mem_we = i_in_valid && o_in_ready && (i_command == CMD_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_trk <= '0;
            r_ended <= 1'b0;
            r_oval <= 1'b0;
            r_cmd <= CMD_TICK;
        end else begin
            r_state <= n_state;
            r_trk <= n_trk;
            r_ended <= n_ended;
            r_oval <= n_oval;
            if (i_in_valid && o_in_ready) r_cmd <= i_command;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_trk = r_trk;
        n_ended = r_ended;
        n_oval = r_oval;
        if (r_oval && i_out_ready) n_oval = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) n_state = S_DISPATCH;
            S_DISPATCH: begin
                n_ended = 1'b0;
                n_trk = '0;
                priority case (r_cmd)
                    CMD_START: n_state = S_LOAD;
                    CMD_STOP: begin
                        n_ended = i_sts.running;
                        n_state = S_OUT;
                    end
                    CMD_TICK: n_state = i_sts.running ? S_SVC : S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_LOAD: n_state = S_LOADWAIT;
            S_LOADWAIT: begin
                if (r_trk == TW'(TRACKS - 1)) n_state = S_OUT;
                else begin
                    n_trk = r_trk + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_SVC: begin
                n_trk = i_sts.svc_trk;
                if (i_sts.svc_hit && i_sts.go_parse) n_state = S_PARSE;
                else n_state = S_MIX;
            end
            S_PARSE: begin
                if (i_sts.is_note) n_state = S_NOTE;
                else if (i_sts.is_end || i_sts.runaway) n_state = S_DONE;
                else n_state = S_READ;
            end
            S_READ: n_state = S_PARSE;
            S_NOTE: n_state = S_NOTEWAIT;
            S_NOTEWAIT: n_state = S_MIX;
            S_MIX: n_state = S_OUT;
            S_DONE: begin
                n_trk = '0;
                if (i_sts.loop_on) n_state = S_LOAD;
                else begin
                    n_ended = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_oval = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_DISPATCH: begin
                if (r_cmd == CMD_START) begin
                    o_cmd.clear_voices = 1'b1;
                    o_cmd.run_on = 1'b1;
                end
                if (r_cmd == CMD_STOP) o_cmd.stop = 1'b1;
                if (r_cmd == CMD_START) o_cmd.load_init = 1'b1;
                if (r_cmd == CMD_TICK && i_sts.running) o_cmd.step_dec = 1'b1;
            end
            S_LOAD: o_cmd.load_ptr = 1'b1;
            S_LOADWAIT: o_cmd.load_cur = 1'b1;
            S_SVC: begin
                o_cmd.svc_count = i_sts.svc_hit;
                o_cmd.step_reload = i_sts.svc_hit && !i_sts.go_parse;
            end
            // the last byte of a runaway walk still takes effect
            S_PARSE: o_cmd.parse = !i_sts.is_note && !i_sts.is_end;
            S_READ: o_cmd.take_byte = 1'b1;
            S_NOTE: o_cmd.note = 1'b1;
            S_NOTEWAIT: begin
                o_cmd.note_adv = 1'b1;
                o_cmd.step_reload = 1'b1;
            end
            S_MIX: o_cmd.mix = 1'b1;
            S_DONE: if (!i_sts.loop_on) o_cmd.stop = 1'b1;
                    else o_cmd.load_init = 1'b1;
            S_OUT: o_cmd.out_load = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

// File: sv/fvsq_dp.sv
// fvsq_dp: song memory, track state, voice mixer and decay
// depends on fvsq_pkg
module fvsq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fvsq_pkg::t_cmd     i_cmd,
    input  logic [fvsq_pkg::TW-1:0] i_trk,
    input  logic               i_mem_we,
    input  fvsq_pkg::t_in_beat i_beat,
    input  logic               i_cfg_we,
    input  logic [fvsq_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [fvsq_pkg::CFG_DW-1:0] i_cfg_data,
    output fvsq_pkg::t_sts     o_sts,
    output logic [7:0]         o_level
);
    import fvsq_pkg::*;

    logic [7:0] r_mem [SONG_BYTES];
    logic [7:0] r_rd;
    logic [AW-1:0] n_raddr;
    logic n_re;

    logic [15:0] r_step_period;
    logic r_loop;
    logic [2:0] r_track_count;
    logic [11:0] r_start [4];

    logic [AW-1:0] r_ptr [TRACKS];
    logic [7:0] r_cur [TRACKS];
    logic [7:0] r_cd [TRACKS];
    logic [4:0] r_slot [2*TRACKS];
    logic [4:0] r_set [TRACKS];
    logic [9:0] r_per [TRACKS];
    logic [15:0] r_ph [TRACKS];
    logic [7:0] r_vol [TRACKS];
    logic [15:0] r_step;
    logic [8:0] r_decay;
    logic r_run;
    logic [7:0] r_level;
    logic [AW:0] r_walk;
    logic r_note_take;
    logic [TW-1:0] r_note_trk;

    logic [3:0] n_active;
    logic [7:0] x;
    logic [3:0] sh;
    logic [10:0] bp;
    logic [9:0] mix;
    logic [8:0] dec_n;
    logic [15:0] ph_n [TRACKS];

    assign o_level = r_level;

    // active track count clamp
    always_comb begin
        n_active = {1'b0, r_track_count};
        if (r_track_count == 3'd0) n_active = 4'd1;
        if (n_active > 4'(TRACKS)) n_active = 4'(TRACKS);
    end

    assign x = r_cur[i_trk];
    assign o_sts.svc_hit = r_step < 16'(n_active);
    assign o_sts.svc_trk = TW'(r_step);
    assign o_sts.go_parse = (r_cur[TW'(r_step)] != 8'd0) && (r_cd[TW'(r_step)] == 8'd0);
    assign o_sts.is_note = x[7];
    assign o_sts.is_end = !x[7] && (x == 8'd1);
    assign o_sts.runaway = (r_walk + 1'b1) >= (AW+1)'(SONG_BYTES);
    assign o_sts.running = r_run;
    assign o_sts.loop_on = r_loop;
    assign sh = {2'b00, x[5:4]} + (r_set[i_trk][3] ? 4'd1 : 4'd4);
    assign bp = base_period(x[3:0]);

    // song memory read address
    always_comb begin
        n_re = 1'b0;
        n_raddr = r_ptr[i_trk];
        if (i_cmd.load_ptr) begin
            n_re = 1'b1;
            n_raddr = AW'(r_start[i_trk]);
        end else if (i_cmd.parse || i_cmd.note_adv) begin
            n_re = 1'b1;
            n_raddr = r_ptr[i_trk] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_we) r_mem[AW'(i_beat.address)] <= i_beat.data;
        if (n_re) r_rd <= r_mem[n_raddr];
    end

    // phase and mix
    always_comb begin
        mix = '0;
        for (int i = 0; i < TRACKS; i++) begin
            ph_n[i] = r_ph[i] + 1'b1;
            if (ph_n[i] == {6'd0, r_per[i]}) ph_n[i] = '0;
            if (4'(i) < n_active &&
                ph_n[i] < {6'd0, (r_per[i] >> (r_set[i][1] ? 2 : 1))})
                mix = mix + 10'(r_vol[i] >> 2);
        end
        dec_n = r_decay - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= 16'd1000;
            r_loop <= 1'b0;
            r_track_count <= 3'd1;
            r_step <= '0;
            r_decay <= '0;
            r_run <= 1'b0;
            r_level <= '0;
            r_walk <= '0;
            for (int i = 0; i < 4; i++) r_start[i] <= '0;
            for (int i = 0; i < TRACKS; i++) begin
                r_ptr[i] <= '0; r_cur[i] <= '0; r_cd[i] <= '0; r_set[i] <= '0;
                r_per[i] <= '0; r_ph[i] <= '0; r_vol[i] <= '0;
                r_slot[2*i] <= '0; r_slot[2*i+1] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_STEP_PERIOD: r_step_period <= i_cfg_data;
                    REG_LOOP_ENABLE: r_loop <= i_cfg_data[0];
                    REG_TRACK_COUNT: r_track_count <= i_cfg_data[2:0];
                    REG_TRACK_START0, REG_TRACK_START1, REG_TRACK_START2,
                    REG_TRACK_START3:
                        r_start[2'(i_cfg_idx - REG_TRACK_START0)] <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_voices) begin
                for (int i = 0; i < TRACKS; i++) begin
                    r_set[i] <= '0; r_per[i] <= '0; r_ph[i] <= '0; r_vol[i] <= '0;
                    r_slot[2*i] <= '0; r_slot[2*i+1] <= '0;
                end
            end
            if (i_cmd.run_on) r_run <= 1'b1;
            if (i_cmd.stop) begin
                r_run <= 1'b0;
                r_level <= '0;
            end
            if (i_cmd.load_init) begin
                r_step <= 16'(n_active);
                r_decay <= 9'd1;
                for (int i = 0; i < TRACKS; i++) r_cd[i] <= '0;
            end
            if (i_cmd.load_ptr)
                r_ptr[i_trk] <= n_raddr;
            if (i_cmd.load_cur) r_cur[i_trk] <= r_rd;
            if (i_cmd.step_dec) r_step <= r_step - 1'b1;
            if (i_cmd.svc_count) begin
                if (r_cur[i_trk] != 8'd0) r_cd[i_trk] <= r_cd[i_trk] - 1'b1;
                r_walk <= '0;
            end
            if (i_cmd.step_reload && i_trk == '0) r_step <= r_step_period;
            // non-note byte effects
            if (i_cmd.parse) begin
                if (x[7:6] == 2'b01) r_slot[{i_trk, x[5]}] <= x[4:0];
                else if (x[7:5] == 3'b001) r_set[i_trk] <= x[4:0];
                r_walk <= r_walk + 1'b1;
                r_ptr[i_trk] <= n_raddr;
            end
            if (i_cmd.take_byte) r_cur[i_trk] <= r_rd;
            if (i_cmd.note) begin
                r_cd[i_trk] <= {3'd0, r_slot[{i_trk, x[6]}]};
                r_per[i_trk] <= (x[3:0] > 4'd11) ? 10'd0 : 10'(bp >> sh);
                r_ph[i_trk] <= '0;
                r_vol[i_trk] <= r_set[i_trk][2] ? 8'h7f : 8'hff;
            end
            if (i_cmd.note_adv) r_ptr[i_trk] <= n_raddr;
            // current byte after a note is taken in the cycle after the read
            if (r_note_take) r_cur[r_note_trk] <= r_rd;
            if (i_cmd.mix) begin
                for (int i = 0; i < TRACKS; i++)
                    if (4'(i) < n_active) r_ph[i] <= ph_n[i];
                r_level <= mix[7:0];
                if ({7'd0, dec_n} < 16'(n_active)) begin
                    if (!r_set[TW'(dec_n)][0])
                        r_vol[TW'(dec_n)] <= r_vol[TW'(dec_n)] - (r_vol[TW'(dec_n)] >> 4);
                end
                r_decay <= (dec_n == '0) ? 9'(DECAY_PERIOD) : dec_n;
            end
        end
    end

    // track whose post-note byte is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_note_take <= 1'b0;
        else r_note_take <= i_cmd.note_adv;
    end
    always_ff @(posedge i_clk) begin
        r_note_trk <= i_trk;
    end
endmodule

// File: sv/fvsq_checker.sv
// fvsq_checker: port level checks for the sequencer
// depends on fvsq_pkg and four_voice_square_music_sequencer
module fvsq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fvsq_pkg::t_out_beat o_out_data
);
    import fvsq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.playing |-> o_out_data.level == 8'd0)
        else $error("level not zero while stopped");
    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ended |-> !o_out_data.playing)
        else $error("ended while playing");
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while busy");
endmodule

bind four_voice_square_music_sequencer fvsq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);

// File: sim/testbench.sv
// testbench for four_voice_square_music_sequencer: directed and random song playback
// checked beat by beat against a behavioral predictor; depends on fvsq_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import fvsq_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_beat           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_beat          o_out_data;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]  i_cfg_idx = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    four_voice_square_music_sequencer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int NOISE_LO       = 2048;
    localparam int NOISE_HI       = 4094;
    localparam int LAST_ADDR      = 4095;
    localparam logic [7:0] BYTE_END   = 8'h01;
    localparam logic [7:0] BYTE_QUIET = 8'h00;

    // sequencer shadow state
    logic [15:0] sh_step_period;
    logic        sh_loop;
    logic [2:0]  sh_track_count;
    logic [11:0] sh_track_start [4];
    logic [7:0]  sh_song [SONG_BYTES];
    logic [11:0] sh_ptr [4];
    logic [7:0]  sh_cur [4];
    logic [7:0]  sh_countdown [4];
    logic [4:0]  sh_slot [8];
    logic [4:0]  sh_settings [4];
    logic [15:0] sh_period [4];
    logic [15:0] sh_phase [4];
    logic [7:0]  sh_volume [4];
    logic [15:0] sh_step;
    logic [8:0]  sh_decay;
    logic        sh_running;
    logic [7:0]  sh_level;

    int note_period [12] = '{1911, 1804, 1703, 1607, 1517, 1432,
                             1351, 1276, 1204, 1136, 1073, 1012};

    t_out_beat expected_levels [$];
    int  fail_count = 0;
    int  beats_sent = 0;
    bit  quiet = 1'b0;
    int  hold_off = 0;
    int  stall_cycles = 0;

    function automatic int active_tracks();
        int n;
        n = sh_track_count;
        if (n == 0) n = 1;
        if (n > TRACKS) n = TRACKS;
        return n;
    endfunction

    function automatic void reload_song();
        sh_step  = 16'(active_tracks());
        sh_decay = 9'd1;
        for (int i = 0; i < 4; i++) begin
            sh_ptr[i]       = sh_track_start[i];
            sh_countdown[i] = 8'd0;
            sh_cur[i]       = sh_song[sh_ptr[i]];
        end
    endfunction

    function automatic logic [7:0] advance_ptr(int d);
        sh_ptr[d] = sh_ptr[d] + 12'd1;
        return sh_song[sh_ptr[d]];
    endfunction

    // service one track, returns 1 on song end
    function automatic bit service_track(int d);
        logic [7:0] x;
        logic [7:0] c;
        int walked;
        int pitch;
        int shift;
        x = sh_cur[d];
        walked = 0;
        if (x == 8'd0) return 1'b0;
        c = sh_countdown[d];
        sh_countdown[d] = c - 8'd1;
        if (c != 8'd0) return 1'b0;
        while (!x[7]) begin
            if (x[7:6] == 2'b01) sh_slot[d*2 + x[5]] = x[4:0];
            else if (x[7:5] == 3'b001) sh_settings[d] = x[4:0];
            else if (x == BYTE_END) return 1'b1;
            walked++;
            if (walked >= SONG_BYTES) return 1'b1;
            x = advance_ptr(d);
            sh_cur[d] = x;
        end
        sh_countdown[d] = 8'(sh_slot[d*2 + x[6]]);
        pitch = x[3:0];
        shift = x[5:4] + (sh_settings[d][3] ? 1 : 4);
        sh_period[d] = (pitch > 11) ? 16'd0 : 16'(note_period[pitch] >> shift);
        sh_phase[d]  = 16'd0;
        sh_volume[d] = sh_settings[d][2] ? 8'h7f : 8'hff;
        sh_cur[d] = advance_ptr(d);
        return 1'b0;
    endfunction

    function automatic t_out_beat predict_level(t_in_beat b);
        t_out_beat r;
        bit done;
        int n;
        int d;
        int mix;
        int s;
        n = active_tracks();
        r.ended = 1'b0;
        case (b.command)
            CMD_WRITE: sh_song[b.address] = b.data;
            CMD_START: begin
                for (int i = 0; i < 8; i++) sh_slot[i] = '0;
                for (int i = 0; i < 4; i++) begin
                    sh_settings[i] = '0; sh_period[i] = '0;
                    sh_phase[i] = '0; sh_volume[i] = '0;
                end
                reload_song();
                sh_running = 1'b1;
            end
            CMD_STOP: begin
                r.ended = sh_running;
                sh_running = 1'b0;
                sh_level = '0;
            end
            default: if (sh_running) begin
                done = 1'b0;
                sh_step = sh_step - 16'd1;
                if (sh_step < n) begin
                    d = sh_step;
                    done = service_track(d);
                    if (!done && d == 0) sh_step = sh_step_period;
                end
                if (done) begin
                    if (sh_loop) begin
                        reload_song();
                    end else begin
                        sh_running = 1'b0;
                        sh_level = '0;
                        r.ended = 1'b1;
                    end
                end else begin
                    mix = 0;
                    for (int i = 0; i < n; i++) begin
                        s = sh_settings[i][1] + 1;
                        sh_phase[i] = sh_phase[i] + 16'd1;
                        if (sh_phase[i] == sh_period[i]) sh_phase[i] = '0;
                        if (sh_phase[i] < (sh_period[i] >> s)) mix += sh_volume[i] >> 2;
                    end
                    sh_level = 8'(mix);
                    sh_decay = sh_decay - 9'd1;
                    if (sh_decay < n) begin
                        d = sh_decay;
                        if (!sh_settings[d][0])
                            sh_volume[d] = sh_volume[d] - (sh_volume[d] >> 4);
                        if (d == 0) sh_decay = 9'(DECAY_PERIOD);
                    end
                end
            end
        endcase
        r.level = sh_level;
        r.playing = sh_running;
        return r;
    endfunction

    // send one beat, sometimes with a random gap in front
    task automatic send_beat(logic [1:0] cmd, logic [11:0] addr, logic [7:0] data);
        t_in_beat b;
        b.command = cmd; b.address = addr; b.data = data;
        if (!quiet && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 50);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        expected_levels.push_back(predict_level(b));
        beats_sent++;
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, 12'($urandom), 8'($urandom));
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DW'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_STEP_PERIOD: sh_step_period = 16'(value);
            REG_LOOP_ENABLE: sh_loop = value[0];
            REG_TRACK_COUNT: sh_track_count = 3'(value);
            default: sh_track_start[idx - REG_TRACK_START0] = 12'(value);
        endcase
    endtask

    task automatic set_song_regs(int step, int loop_on, int count,
                                 int s0, int s1, int s2, int s3);
        settle();
        cfg_write(REG_STEP_PERIOD, step);
        cfg_write(REG_LOOP_ENABLE, loop_on);
        cfg_write(REG_TRACK_COUNT, count);
        cfg_write(REG_TRACK_START0, s0);
        cfg_write(REG_TRACK_START0 + 3'd1, s1);
        cfg_write(REG_TRACK_START0 + 3'd2, s2);
        cfg_write(REG_TRACK_START0 + 3'd3, s3);
    endtask

    function automatic logic [7:0] random_song_byte();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 8'h80 | 8'($urandom_range(127));
        if (p < 65) return 8'h40 | 8'($urandom_range(63));
        if (p < 80) return 8'h20 | 8'($urandom_range(31));
        if (p < 95) return 8'($urandom_range(31));
        return BYTE_END;
    endfunction

    // a track is random bytes closed by an end flag so no walk leaves it
    task automatic write_track(int base, int len);
        for (int j = 0; j < len - 1; j++)
            send_beat(CMD_WRITE, 12'(base + j), random_song_byte());
        send_beat(CMD_WRITE, 12'(base + len - 1), BYTE_END);
    endtask

    task automatic send_noise();
        int p;
        p = $urandom_range(9);
        if (p < 6) send_beat(CMD_WRITE, 12'($urandom_range(NOISE_LO, NOISE_HI)), 8'($urandom));
        else if (p < 8) send_beat(CMD_STOP, 12'($urandom), 8'($urandom));
        else send_beat(CMD_START, 12'($urandom), 8'($urandom));
    endtask

    task automatic test_stopped_commands();
        send_tick();
        send_beat(CMD_STOP, 12'hfff, 8'hff);
        send_beat(CMD_WRITE, 12'(LAST_ADDR), BYTE_END);
        send_beat(CMD_WRITE, 12'(NOISE_LO), 8'h00);
        send_beat(CMD_WRITE, 12'(NOISE_HI), 8'hff);
        send_tick();
    endtask

    task automatic test_directed_song();
        logic [7:0] bytes [11] = '{8'h45, 8'h63, 8'h2c, 8'h80, 8'hcb, 8'h9c,
                                   8'hbf, 8'h22, 8'h02, 8'h85, BYTE_QUIET};
        for (int j = 0; j < 11; j++) send_beat(CMD_WRITE, 12'(j), bytes[j]);
        send_beat(CMD_WRITE, 12'd100, 8'h43);
        send_beat(CMD_WRITE, 12'd101, 8'h81);
        send_beat(CMD_WRITE, 12'd102, BYTE_END);
        // all four tracks, the last one ends at once and loops
        set_song_regs(4, 1, 4, 0, 100, 0, LAST_ADDR);
        send_beat(CMD_START, '0, '0);
        repeat (30) send_tick();
        // two tracks, no loop, the second one runs into its end flag
        set_song_regs(4, 0, 2, 0, 100, 0, LAST_ADDR);
        send_beat(CMD_START, '0, '0);
        repeat (40) send_tick();
        send_beat(CMD_STOP, '0, '0);
    endtask

    task automatic test_config_extremes();
        set_song_regs(65535, 1, 7, 0, 100, 0, LAST_ADDR);
        send_beat(CMD_START, '0, '0);
        repeat (12) send_tick();
        set_song_regs(4, 0, 0, 0, 100, 0, LAST_ADDR);
        send_beat(CMD_START, '0, '0);
        repeat (12) send_tick();
        send_beat(CMD_STOP, '0, '0);
    endtask

    task automatic play_random_phase(int ticks);
        int s [4];
        int len;
        send_beat(CMD_STOP, '0, '0);
        for (int k = 0; k < 4; k++) begin
            s[k] = k * 512 + $urandom_range(0, 400);
            len = $urandom_range(3, 24);
            write_track(s[k], len);
        end
        set_song_regs(($urandom_range(9) == 0) ? $urandom_range(4, 65535) : $urandom_range(4, 12),
                      $urandom_range(1), $urandom_range(7), s[0], s[1], s[2], s[3]);
        send_beat(CMD_START, '0, '0);
        for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(99) < 8) send_noise();
            else send_tick();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        play_random_phase(40);
    endtask

    task automatic test_random_play();
        quiet = 1'b1;
        play_random_phase(120);
        quiet = 1'b0;
        while (beats_sent < 1550) play_random_phase($urandom_range(60, 110));
    endtask

    // result check and receiver stalls
    always @(posedge i_clk) begin
        t_out_beat want;
        if (o_out_valid && i_out_ready) begin
            if (expected_levels.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_levels.pop_front();
                if (o_out_data.level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, o_out_data.level);
                    fail_count++;
                end
                if (o_out_data.playing !== want.playing) begin
                    $error("playing: expected %0d, got %0d", want.playing, o_out_data.playing);
                    fail_count++;
                end
                if (o_out_data.ended !== want.ended) begin
                    $error("ended: expected %0d, got %0d", want.ended, o_out_data.ended);
                    fail_count++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("four_voice_square_music_sequencer: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        sh_step_period = 16'd1000;
        sh_loop = 1'b0;
        sh_track_count = 3'd1;
        for (int i = 0; i < 4; i++) begin
            sh_track_start[i] = '0; sh_ptr[i] = '0; sh_cur[i] = '0;
            sh_countdown[i] = '0; sh_settings[i] = '0; sh_period[i] = '0;
            sh_phase[i] = '0; sh_volume[i] = '0;
        end
        for (int i = 0; i < 8; i++) sh_slot[i] = '0;
        for (int i = 0; i < SONG_BYTES; i++) sh_song[i] = '0;
        sh_step = '0;
        sh_decay = '0;
        sh_running = 1'b0;
        sh_level = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stopped_commands();
        test_directed_song();
        test_config_extremes();
        test_backpressure();
        test_random_play();
        settle();
        if (fail_count == 0) begin
            $display("four_voice_square_music_sequencer: match");
        end else begin
            $display("four_voice_square_music_sequencer: mismatch");
        end
        $finish;
    end

endmodule
